// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the evaluator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// ----- hdl/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// RPN evaluator package
// Request and status codes, Q16.16 limits and controller/datapath links.
// ----------------------------------------------------------------------------
package rpn_pkg;

    typedef logic [2:0] t_req;

    localparam t_req REQ_PUSH  = 3'd0;
    localparam t_req REQ_ADD   = 3'd1;
    localparam t_req REQ_SUB   = 3'd2;
    localparam t_req REQ_MUL   = 3'd3;
    localparam t_req REQ_DIV   = 3'd4;
    localparam t_req REQ_PRINT = 3'd5;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_FULL    = 3'd1;
    localparam t_status ST_EMPTY   = 3'd2;
    localparam t_status ST_ZDIV    = 3'd3;
    localparam t_status ST_UNKNOWN = 3'd4;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    localparam logic [5:0] DIV_STEPS = 6'd32;

    typedef struct packed {
        logic load;
        logic unknown;
        logic pop;
        logic take_a;
        logic take_b;
        logic mul;
        logic div_start;
        logic zdiv;
        logic push;
        t_req sel;
        logic print;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic b_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/rpn_div.sv -----
// ----------------------------------------------------------------------------
// RPN divider
// Radix-2 restoring divider for saturated Q16.16 (a << 16) / b, one bit a cycle.
// ----------------------------------------------------------------------------
module rpn_div
    import rpn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic        r_ovf;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;

    logic [31:0] w_mag_a;
    logic [31:0] w_mag_b;
    logic [31:0] w_hi;
    logic        w_ovf;
    logic [32:0] w_shift;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_mag_a = i_dividend[31] ? (~i_dividend + 32'd1) : i_dividend;
    assign w_mag_b = i_divisor[31]  ? (~i_divisor + 32'd1)  : i_divisor;
    assign w_hi    = {16'd0, w_mag_a[31:16]};
    assign w_ovf   = (w_hi >= w_mag_b);

    assign w_shift = {r_rem, r_quo[31]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_ovf ? 32'd0 : w_hi;
            r_quo <= {w_mag_a[15:0], 16'd0};
            r_dvs <= w_mag_b;
            r_neg <= i_dividend[31] ^ i_divisor[31];
            r_ovf <= w_ovf;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_shift[31:0];
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    always_comb begin
        if (r_ovf) begin
            o_quotient = r_neg ? Q_MIN : Q_MAX;
        end else if (r_neg) begin
            o_quotient = (r_quo > Q_MIN) ? Q_MIN : (~r_quo + 32'd1);
        end else begin
            o_quotient = r_quo[31] ? Q_MAX : r_quo;
        end
    end

    assign o_done = r_done;

endmodule

// ----- hdl/rpn_dp.sv -----
// ----------------------------------------------------------------------------
// RPN datapath
// Operand stack memory, stack pointer, arithmetic units and result register.
// ----------------------------------------------------------------------------
module rpn_dp
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [31:0] i_operand,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [31:0] o_value,
    output logic        o_has_value,
    output logic [2:0]  o_status,
    output logic [7:0]  o_depth
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    logic [31:0] mem [STACK_DEPTH];

    logic [SP_W-1:0] r_sp;
    logic            r_pop_hit;
    logic            r_empty;
    logic            r_full;
    logic            r_zdiv;
    logic            r_unknown;
    logic [31:0]     r_rd;
    logic [31:0]     r_operand;
    logic [31:0]     r_a;
    logic [31:0]     r_b;
    logic [63:0]     r_prod;

    logic            r_out_valid;
    logic [31:0]     r_out_value;
    logic            r_out_has_value;
    t_status         r_out_status;
    logic [7:0]      r_out_depth;

    logic [SP_W-1:0] w_sp_m1;
    logic            w_sp_zero;
    logic            w_sp_full;
    logic [31:0]     w_pop_val;
    logic [32:0]     w_sum;
    logic [32:0]     w_dif;
    logic [31:0]     w_add_sat;
    logic [31:0]     w_sub_sat;
    logic [31:0]     w_mul_sat;
    logic [31:0]     w_quo;
    logic            w_div_done;
    logic [31:0]     w_push_data;
    t_status         w_status;
    logic [SP_W+7:0] w_sp_ext;

    assign w_sp_m1   = r_sp - SP_W'(1);
    assign w_sp_zero = (r_sp == '0);
    assign w_sp_full = (r_sp == SP_FULL);
    assign w_pop_val = r_pop_hit ? r_rd : 32'd0;

    assign w_sum = {r_a[31], r_a} + {r_b[31], r_b};
    assign w_dif = {r_a[31], r_a} - {r_b[31], r_b};
    assign w_add_sat = (w_sum[32] != w_sum[31]) ? (w_sum[32] ? Q_MIN : Q_MAX) : w_sum[31:0];
    assign w_sub_sat = (w_dif[32] != w_dif[31]) ? (w_dif[32] ? Q_MIN : Q_MAX) : w_dif[31:0];
    assign w_mul_sat = ((&r_prod[63:47]) || !(|r_prod[63:47])) ? r_prod[47:16]
                     : (r_prod[63] ? Q_MIN : Q_MAX);

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        case (i_cmd.sel)
            REQ_ADD: w_push_data = w_add_sat;
            REQ_SUB: w_push_data = w_sub_sat;
            REQ_MUL: w_push_data = w_mul_sat;
            REQ_DIV: w_push_data = w_quo;
            default: w_push_data = r_operand;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_pop_hit <= 1'b0;
            r_empty   <= 1'b0;
            r_full    <= 1'b0;
            r_zdiv    <= 1'b0;
            r_unknown <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_empty   <= 1'b0;
                r_full    <= 1'b0;
                r_zdiv    <= 1'b0;
                r_unknown <= i_cmd.unknown;
            end
            if (i_cmd.pop) begin
                if (!w_sp_zero) begin
                    r_sp      <= w_sp_m1;
                    r_pop_hit <= 1'b1;
                end else begin
                    r_pop_hit <= 1'b0;
                    r_empty   <= 1'b1;
                end
            end
            if (i_cmd.push) begin
                if (!w_sp_full) begin
                    r_sp <= r_sp + SP_W'(1);
                end else begin
                    r_full <= 1'b1;
                end
            end
            if (i_cmd.zdiv) begin
                r_zdiv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_sp_full) begin
            mem[r_sp[AW-1:0]] <= w_push_data;
        end
        if (i_cmd.pop && !w_sp_zero) begin
            r_rd <= mem[w_sp_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_operand <= i_operand;
        end
        if (i_cmd.take_a) begin
            r_a <= w_pop_val;
        end
        if (i_cmd.take_b) begin
            r_b <= w_pop_val;
        end
        if (i_cmd.mul) begin
            r_prod <= 64'($signed(r_a)) * 64'($signed(r_b));
        end
    end

    always_comb begin
        if (r_empty) begin
            w_status = ST_EMPTY;
        end else if (r_full) begin
            w_status = ST_FULL;
        end else if (r_zdiv) begin
            w_status = ST_ZDIV;
        end else if (r_unknown) begin
            w_status = ST_UNKNOWN;
        end else begin
            w_status = ST_OK;
        end
    end

    assign w_sp_ext = {8'd0, r_sp};

    // hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value     <= i_cmd.print ? r_b : 32'd0;
            r_out_has_value <= i_cmd.print;
            r_out_status    <= w_status;
            r_out_depth     <= w_sp_ext[7:0];
        end
    end

    assign o_sts.b_zero   = (w_pop_val == 32'd0);
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_has_value = r_out_has_value;
    assign o_status    = r_out_status;
    assign o_depth     = r_out_depth;

endmodule

// ----- hdl/rpn_ctrl.sv -----
// ----------------------------------------------------------------------------
// RPN controller
// Sequences pops, arithmetic, push and result transfer for one token.
// ----------------------------------------------------------------------------
module rpn_ctrl
    import rpn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_req i_req_type,
    output logic o_in_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POPB,
        S_GETB,
        S_POPA,
        S_GETA,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_PUSH,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_req   r_req;
    logic   w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd     = '0;
        o_cmd.sel = r_req;
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load    = w_accept;
                o_cmd.unknown = (i_req_type > REQ_PRINT);
                if (w_accept) begin
                    case (i_req_type) inside
                        REQ_PUSH: n_state = S_PUSH;
                        REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_PRINT: n_state = S_POPB;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_POPB: begin
                o_cmd.pop = 1'b1;
                n_state   = S_GETB;
            end
            S_GETB: begin
                o_cmd.take_b = 1'b1;
                if (r_req == REQ_PRINT) begin
                    n_state = S_DONE;
                end else if ((r_req == REQ_DIV) && i_sts.b_zero) begin
                    o_cmd.zdiv = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_POPA;
                end
            end
            S_POPA: begin
                o_cmd.pop = 1'b1;
                n_state   = S_GETA;
            end
            S_GETA: begin
                o_cmd.take_a = 1'b1;
                if (r_req == REQ_MUL) begin
                    n_state = S_MUL;
                end else if (r_req == REQ_DIV) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PUSH;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                o_cmd.print  = (r_req == REQ_PRINT);
                o_cmd.finish = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_PUSH;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_req <= i_req_type;
            end
        end
    end

endmodule

// ----- hdl/rpn_stack_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Reverse Polish evaluator over a bounded stack of signed Q16.16 values.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one scanned token (request code
// and Q16.16 operand); a transfer happens when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall carry one result per token: the
// printed value, a print flag, a status code and the stack depth.
// One token at a time. A divide waits on the bit-serial divider, which is
// the slowest step; a zero divisor ends a divide after the first pop.
// The block is ready for the next token in the same cycle as its result
// becomes valid, so each token occupies it until its result is loaded.
// The stack is a single-port memory, one pop or push per cycle.
// The result register holds while i_out_stall is high; a finished token then
// waits until it frees, while o_in_stall stays high.
// Synchronous active-low reset empties the stack and drops any pending result;
// stack contents need no clearing, since only entries below the pointer are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpn_stack_evaluator_top
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_operand,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_value,
    output logic        o_has_value,
    output logic [2:0]  o_status,
    output logic [7:0]  o_depth
);

    t_cmd w_cmd;
    t_sts w_sts;

    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_operand   (i_operand),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_has_value (o_has_value),
        .o_status    (o_status),
        .o_depth     (o_depth)
    );

    `ASSERT_NEVER(a_finish_needs_room, i_clk, i_rst_n, w_cmd.finish && !w_sts.out_free, "result loaded over an untaken transfer")
    `ASSERT_PROP(a_accept_then_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input stall not raised after transfer")
    `ASSERT_PROP(a_print_status, i_clk, i_rst_n, (o_out_valid && o_has_value) |-> (o_status == ST_OK || o_status == ST_EMPTY), "bad status on print")
    `ASSERT_PROP(a_empty_print_zero, i_clk, i_rst_n, (o_out_valid && o_has_value && o_status == ST_EMPTY) |-> (o_value == 32'd0), "empty print gave nonzero value")

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// RPN stack evaluator testbench
// Drives scanned tokens through the valid/stall input channel with random
// gaps, predicts each result against a private copy of the Q16.16 operand
// stack, and compares every output transfer field by field. Includes a long
// receiver hold-off and a full drain pause between token phases.
// ----------------------------------------------------------------------------
module tb_top;
    import rpn_pkg::*;

    localparam int     STACK_DEPTH = 128;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     TAIL_CYCLES = 60;
    localparam int     RANDOM_TOKENS = 1600;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam t_req   REQ_UNKNOWN = 3'd6;
    localparam t_req   REQ_SPARE = 3'd7;

    typedef struct {
        t_req        req;
        logic [31:0] opnd;
    } token_t;

    typedef struct packed {
        logic [31:0] value;
        logic        has_value;
        t_status     status;
        logic [7:0]  depth;
    } eval_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_req        req_type = REQ_PUSH;
    logic [31:0] operand = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] value;
    logic        has_value;
    t_status     status;
    logic [7:0]  depth;

    token_t       pend_q[$];
    eval_result_t result_q[$];

    logic [31:0] eval_stack [STACK_DEPTH];
    int unsigned eval_sp = 0;

    int  n_in = 0;
    int  errors = 0;
    int  cycles = 0;
    int  gen_depth = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  quiet = 1'b0;

    rpn_stack_evaluator_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_operand   (operand),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_value     (value),
        .o_has_value (has_value),
        .o_status    (status),
        .o_depth     (depth)
    );

    always #5 clk = ~clk;

    function automatic longint saturate_q(input longint v);
        if (v > SAT_HI) begin
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            return SAT_LO;
        end
        return v;
    endfunction

    function bit push_operand(input longint v);
        if (eval_sp < STACK_DEPTH) begin
            eval_stack[eval_sp] = v[31:0];
            eval_sp++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function longint pop_operand(inout bit empty);
        if (eval_sp > 0) begin
            eval_sp--;
            return longint'(signed'(eval_stack[eval_sp]));
        end
        empty = 1'b1;
        return 0;
    endfunction

    function eval_result_t evaluate_token(input t_req req, input logic [31:0] opnd);
        eval_result_t r;
        bit           empty;
        bit           full;
        longint       a;
        longint       b;
        empty = 1'b0;
        full = 1'b0;
        r = '0;
        r.status = ST_OK;
        case (req)
            REQ_PUSH: begin
                full = !push_operand(longint'(signed'(opnd)));
            end
            REQ_ADD, REQ_SUB, REQ_MUL: begin
                b = pop_operand(empty);
                a = pop_operand(empty);
                case (req)
                    REQ_ADD: a = saturate_q(a + b);
                    REQ_SUB: a = saturate_q(a - b);
                    default: a = saturate_q((a * b) >>> 16);
                endcase
                full = !push_operand(a);
            end
            REQ_DIV: begin
                b = pop_operand(empty);
                if (b == 0) begin
                    if (!empty) begin
                        r.status = ST_ZDIV;
                    end
                end else begin
                    a = pop_operand(empty);
                    full = !push_operand(saturate_q((a * 65536) / b));
                end
            end
            REQ_PRINT: begin
                r.value = 32'(pop_operand(empty));
                r.has_value = 1'b1;
            end
            default: begin
                r.status = ST_UNKNOWN;
            end
        endcase
        if (empty) begin
            r.status = ST_EMPTY;
        end else if (full) begin
            r.status = ST_FULL;
        end
        r.depth = eval_sp[7:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return Q_MAX;
            2: return Q_MIN;
            3: return 32'($urandom_range(0, 15)) << 16;
            4: return -(32'($urandom_range(0, 15)) << 16);
            5: return 32'($urandom_range(0, 3)) - 32'd2;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_token(input t_req req, input logic [31:0] opnd);
        token_t tok;
        tok.req = req;
        tok.opnd = opnd;
        pend_q.push_back(tok);
        case (req)
            REQ_PUSH: gen_depth = (gen_depth < STACK_DEPTH) ? gen_depth + 1 : gen_depth;
            REQ_ADD, REQ_SUB, REQ_MUL: gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 1;
            REQ_DIV, REQ_PRINT: gen_depth = (gen_depth >= 1) ? gen_depth - 1 : 0;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || in_valid || result_q.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic report_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Driver: hold a stalled token, otherwise idle or advance to the next one.
    always @(posedge clk) begin : drive_tokens
        token_t tok;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall) begin
                result_q.push_back(evaluate_token(req_type, operand));
                n_in <= n_in + 1;
            end
            if (!(in_valid && in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    tok = pend_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= tok.req;
                    operand <= tok.opnd;
                    gap_left = quiet ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge clk) begin : watch_results
        eval_result_t exp_r;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual value %0h status %0d",
                             $time, value, status);
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    report_field("value", exp_r.value, value);
                    report_field("has_value", exp_r.has_value, has_value);
                    report_field("status", exp_r.status, status);
                    report_field("depth", exp_r.depth, depth);
                end
            end
            if (!hold_done && n_in >= 500) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_left = quiet ? 0 : pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int   queued;
        int   mode;
        int   len;
        int   r;
        bit   paused;
        t_req op;
        queued = 0;
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_token(REQ_PRINT, $urandom());
        queue_token(REQ_ADD, $urandom());
        queue_token(REQ_PRINT, $urandom());
        queue_token(REQ_DIV, $urandom());
        queue_token(REQ_PUSH, Q_MAX);
        queue_token(REQ_PUSH, Q_MAX);
        queue_token(REQ_ADD, $urandom());
        queue_token(REQ_PUSH, Q_MIN);
        queue_token(REQ_SUB, $urandom());
        queue_token(REQ_PUSH, Q_MIN);
        queue_token(REQ_PUSH, 32'h0000_0001);
        queue_token(REQ_SUB, $urandom());
        queue_token(REQ_MUL, $urandom());
        queue_token(REQ_PUSH, 32'h0003_0000);
        queue_token(REQ_PUSH, 32'hFFFE_8000);
        queue_token(REQ_MUL, $urandom());
        queue_token(REQ_PUSH, 32'h0000_0001);
        queue_token(REQ_PUSH, 32'hFFFF_FFFF);
        queue_token(REQ_MUL, $urandom());
        queue_token(REQ_PUSH, 32'h0000_0000);
        queue_token(REQ_DIV, $urandom());
        queue_token(REQ_PUSH, Q_MIN);
        queue_token(REQ_PUSH, 32'hFFFF_0000);
        queue_token(REQ_DIV, $urandom());
        queue_token(REQ_UNKNOWN, 32'hFFFF_FFFF);
        queue_token(REQ_SPARE, 32'h0000_0000);
        repeat (4) queue_token(REQ_PRINT, $urandom());
        wait_drained();

        while (queued < RANDOM_TOKENS) begin
            @(negedge clk);
            quiet = ($urandom_range(0, 5) == 0);
            mode = $urandom_range(0, 9);
            len = (mode == 6) ? 200 : $urandom_range(40, 160);
            repeat (len) begin
                r = $urandom_range(0, 99);
                op = t_req'($urandom_range(REQ_ADD, REQ_PRINT));
                case (mode)
                    6: begin
                        if (r < 90) queue_token(REQ_PUSH, pick_operand());
                        else queue_token(op, $urandom());
                    end
                    7: begin
                        if (r < 10) queue_token(REQ_PUSH, pick_operand());
                        else queue_token(op, $urandom());
                    end
                    8: queue_token(t_req'($urandom_range(0, 7)), $urandom());
                    9: queue_token(t_req'($urandom_range(REQ_ADD, REQ_SPARE)), $urandom());
                    default: begin
                        if (gen_depth < 2 || (gen_depth <= 20 && r < 50)) begin
                            queue_token(REQ_PUSH, pick_operand());
                        end else begin
                            queue_token(op, $urandom());
                        end
                    end
                endcase
                queued++;
            end
            if (!paused && queued >= RANDOM_TOKENS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            while (pend_q.size() > 64) begin
                @(negedge clk);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rpn_pkg.sv
hdl/rpn_div.sv
hdl/rpn_dp.sv
hdl/rpn_ctrl.sv
hdl/rpn_stack_evaluator_top.sv
verif/tb_top.sv
